[hw/rtl/sbit_pkg.sv]
package sbit_pkg;

  localparam int NUM_AXES  = 3;
  localparam int NUM_FACES = 6;

  // Per-face control bits that ride along with the divider data
  typedef struct packed {
    logic den_neg;  // entering face
    logic neg;      // quotient sign
    logic big;      // quotient at least two, past any bound that matters
    logic skip;     // parallel face, start inside
    logic miss;     // parallel face, start outside
  } face_flags_t;

endpackage

[hw/rtl/sbit_seg_if.sv]
interface sbit_seg_if #(
  parameter int W = 32
) ();
  logic valid;
  logic ready;
  logic signed [W-1:0] start_x;
  logic signed [W-1:0] start_y;
  logic signed [W-1:0] start_z;
  logic signed [W-1:0] end_x;
  logic signed [W-1:0] end_y;
  logic signed [W-1:0] end_z;
  logic signed [W-1:0] box_low_x;
  logic signed [W-1:0] box_low_y;
  logic signed [W-1:0] box_low_z;
  logic signed [W-1:0] box_high_x;
  logic signed [W-1:0] box_high_y;
  logic signed [W-1:0] box_high_z;

  modport source(output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                 box_low_x, box_low_y, box_low_z, box_high_x, box_high_y, box_high_z,
                 input ready);
  modport sink(input valid, start_x, start_y, start_z, end_x, end_y, end_z,
               box_low_x, box_low_y, box_low_z, box_high_x, box_high_y, box_high_z,
               output ready);
endinterface

[hw/rtl/sbit_res_if.sv]
interface sbit_res_if ();
  logic valid;
  logic ready;
  logic hit;
  logic zero_length;

  modport source(output valid, hit, zero_length, input ready);
  modport sink(input valid, hit, zero_length, output ready);
endinterface

[hw/rtl/segment_box_intersection_test.sv]
// Segment versus axis-aligned box test, 3D slab clipping in signed fixed point.
// seg: one transfer carries a segment (start, end) and a box (low, high corner),
//   COORD_WIDTH bits each with FRAC_BITS fraction bits.
// res: one transfer per segment: hit, and zero_length when start equals end.
// cfg_wr_en / cfg_wr_data write the 16-bit parallel threshold (raw fixed point)
//   at any clock edge; write it only while no segment is in flight.
// The pipeline is one setup stage, a row of FRAC_BITS + 1 divider cells each
//   giving one quotient bit for all six faces, and one stage that merges the
//   bounds into the result register.
// Throughput is one segment per cycle while res is ready; every stage holds its own valid bit.
// When res stalls, items move up into empty stages, so seg stays ready until
//   every stage is full, then back-pressure reaches seg.ready.
// Reset clears all valid bits and sets the threshold to 1.
module segment_box_intersection_test #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  sbit_seg_if.sink seg,
  sbit_res_if.source res
);
  import sbit_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int RW = CW + 2;
  localparam int MW = CW + 1;
  localparam int QW = FRAC_BITS + 2;
  localparam int NS = FRAC_BITS + 1;

  logic [15:0] thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 16'd1;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  logic [NUM_AXES-1:0][CW-1:0] start_pt, end_pt, box_lo, box_hi;
  assign start_pt = {CW'(seg.start_z), CW'(seg.start_y), CW'(seg.start_x)};
  assign end_pt   = {CW'(seg.end_z), CW'(seg.end_y), CW'(seg.end_x)};
  assign box_lo   = {CW'(seg.box_low_z), CW'(seg.box_low_y), CW'(seg.box_low_x)};
  assign box_hi   = {CW'(seg.box_high_z), CW'(seg.box_high_y), CW'(seg.box_high_x)};

  logic                                  v     [NS+1];
  logic                                  rdy   [NS+1];
  logic [NUM_FACES-1:0][RW-1:0]          r_s   [NS+1];
  logic [NUM_FACES-1:0][MW-1:0]          d_s   [NS+1];
  logic [NUM_FACES-1:0][QW-1:0]          q_s   [NS+1];
  face_flags_t [NUM_FACES-1:0]           fl_s  [NS+1];
  logic                                  zl_s  [NS+1];
  logic                                  fin_ready;

  assign q_s[0] = '0;

  sbit_prep #(.CW(CW)) u_prep (
    .clk(clk), .rst(rst),
    .in_valid(seg.valid), .in_ready(seg.ready),
    .start_pt(start_pt), .end_pt(end_pt), .box_lo(box_lo), .box_hi(box_hi),
    .thr(thr),
    .out_valid(v[0]), .out_ready(rdy[0]),
    .r_out(r_s[0]), .d_out(d_s[0]), .flags_out(fl_s[0]), .zlen_out(zl_s[0])
  );

  for (genvar k = 0; k < NS; k++) begin : g_cell
    sbit_cell #(.CW(CW), .QW(QW)) u_cell (
      .clk(clk), .rst(rst),
      .in_valid(v[k]), .in_ready(rdy[k]),
      .r_in(r_s[k]), .d_in(d_s[k]), .q_in(q_s[k]), .flags_in(fl_s[k]), .zlen_in(zl_s[k]),
      .out_valid(v[k+1]), .out_ready(k == NS - 1 ? fin_ready : rdy[k+1]),
      .r_out(r_s[k+1]), .d_out(d_s[k+1]), .q_out(q_s[k+1]), .flags_out(fl_s[k+1]),
      .zlen_out(zl_s[k+1])
    );
  end

  assign rdy[NS] = fin_ready;

  sbit_final #(.FB(FRAC_BITS)) u_final (
    .clk(clk), .rst(rst),
    .in_valid(v[NS]), .in_ready(fin_ready),
    .q_in(q_s[NS]), .flags_in(fl_s[NS]), .zlen_in(zl_s[NS]),
    .out_valid(res.valid), .out_ready(res.ready),
    .hit(res.hit), .zero_length(res.zero_length)
  );

  a_zero_no_hit: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.zero_length |-> !res.hit)
    else $error("zero-length segment reported as hit");

  a_reset_empty: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid right after reset");

  a_thr_write: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> thr == $past(cfg_wr_data))
    else $error("threshold write lost");

endmodule

[hw/rtl/sbit_prep.sv]
module sbit_prep #(
  parameter int CW = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [sbit_pkg::NUM_AXES-1:0][CW-1:0] start_pt,
  input  logic [sbit_pkg::NUM_AXES-1:0][CW-1:0] end_pt,
  input  logic [sbit_pkg::NUM_AXES-1:0][CW-1:0] box_lo,
  input  logic [sbit_pkg::NUM_AXES-1:0][CW-1:0] box_hi,
  input  logic [15:0] thr,
  output logic out_valid,
  input  logic out_ready,
  output logic [sbit_pkg::NUM_FACES-1:0][CW+1:0] r_out,
  output logic [sbit_pkg::NUM_FACES-1:0][CW:0] d_out,
  output sbit_pkg::face_flags_t [sbit_pkg::NUM_FACES-1:0] flags_out,
  output logic zlen_out
);
  import sbit_pkg::*;

  localparam int DW = CW + 2;
  localparam int MW = CW + 1;
  localparam int RW = CW + 2;

  logic [NUM_FACES-1:0][RW-1:0] r_next;
  logic [NUM_FACES-1:0][MW-1:0] d_next;
  face_flags_t [NUM_FACES-1:0] flags_next;
  logic zlen_next;

  for (genvar f = 0; f < NUM_FACES; f++) begin : g_face
    localparam int AX = f / 2;
    logic signed [DW-1:0] sv, ev, lv, hv, dir, num, den;
    logic [MW-1:0] mn, md;
    logic par;
    always_comb begin
      sv  = DW'(signed'(start_pt[AX]));
      ev  = DW'(signed'(end_pt[AX]));
      lv  = DW'(signed'(box_lo[AX]));
      hv  = DW'(signed'(box_hi[AX]));
      dir = ev - sv;
      if (f % 2 == 0) begin
        num = sv - lv;
        den = -dir;
      end else begin
        num = hv - sv;
        den = dir;
      end
      mn  = num[DW-1] ? MW'(-num) : MW'(num);
      md  = den[DW-1] ? MW'(-den) : MW'(den);
      par = (md == '0) || (md < MW'(thr));
      flags_next[f].den_neg = den[DW-1];
      flags_next[f].neg     = num[DW-1] ^ den[DW-1];
      flags_next[f].big     = {1'b0, mn} >= {md, 1'b0};
      flags_next[f].skip    = par && !num[DW-1];
      flags_next[f].miss    = par && num[DW-1];
      r_next[f] = RW'(mn);
      d_next[f] = md;
    end
  end

  assign zlen_next = (start_pt == end_pt);
  assign in_ready  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      r_out     <= r_next;
      d_out     <= d_next;
      flags_out <= flags_next;
      zlen_out  <= zlen_next;
    end
  end

endmodule

[hw/rtl/sbit_cell.sv]
module sbit_cell #(
  parameter int CW = 32,
  parameter int QW = 18
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [sbit_pkg::NUM_FACES-1:0][CW+1:0] r_in,
  input  logic [sbit_pkg::NUM_FACES-1:0][CW:0] d_in,
  input  logic [sbit_pkg::NUM_FACES-1:0][QW-1:0] q_in,
  input  sbit_pkg::face_flags_t [sbit_pkg::NUM_FACES-1:0] flags_in,
  input  logic zlen_in,
  output logic out_valid,
  input  logic out_ready,
  output logic [sbit_pkg::NUM_FACES-1:0][CW+1:0] r_out,
  output logic [sbit_pkg::NUM_FACES-1:0][CW:0] d_out,
  output logic [sbit_pkg::NUM_FACES-1:0][QW-1:0] q_out,
  output sbit_pkg::face_flags_t [sbit_pkg::NUM_FACES-1:0] flags_out,
  output logic zlen_out
);
  import sbit_pkg::*;

  localparam int RW = CW + 2;

  logic [NUM_FACES-1:0][RW-1:0] r_next;
  logic [NUM_FACES-1:0][QW-1:0] q_next;

  // One restoring step per face: subtract the divisor if it fits, then double
  always_comb begin
    for (int f = 0; f < NUM_FACES; f++) begin
      if (r_in[f] >= RW'(d_in[f])) begin
        r_next[f] = (r_in[f] - RW'(d_in[f])) << 1;
        q_next[f] = {q_in[f][QW-2:0], 1'b1};
      end else begin
        r_next[f] = r_in[f] << 1;
        q_next[f] = {q_in[f][QW-2:0], 1'b0};
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      r_out     <= r_next;
      d_out     <= d_in;
      q_out     <= q_next;
      flags_out <= flags_in;
      zlen_out  <= zlen_in;
    end
  end

endmodule

[hw/rtl/sbit_final.sv]
module sbit_final #(
  parameter int FB = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [sbit_pkg::NUM_FACES-1:0][FB+1:0] q_in,
  input  sbit_pkg::face_flags_t [sbit_pkg::NUM_FACES-1:0] flags_in,
  input  logic zlen_in,
  output logic out_valid,
  input  logic out_ready,
  output logic hit,
  output logic zero_length
);
  import sbit_pkg::*;

  localparam int QW = FB + 2;
  localparam int TW = FB + 3;

  logic hit_next;
  logic signed [TW-1:0] te, tl, t;
  logic [QW-1:0] mg;

  // Walk the faces in order, tightening the entry and leave bounds
  always_comb begin
    hit_next = !zlen_in;
    te = '0;
    tl = TW'(1) <<< FB;
    t  = '0;
    mg = '0;
    for (int f = 0; f < NUM_FACES; f++) begin
      mg = flags_in[f].big ? (QW'(1) << (FB + 1)) : q_in[f];
      t  = flags_in[f].neg ? -signed'(TW'(mg)) : signed'(TW'(mg));
      if (hit_next && !flags_in[f].skip) begin
        if (flags_in[f].miss) begin
          hit_next = 1'b0;
        end else if (flags_in[f].den_neg) begin
          if (t > te) begin
            te = t;
            if (te > tl) hit_next = 1'b0;
          end
        end else begin
          if (t < tl) begin
            tl = t;
            if (tl < te) hit_next = 1'b0;
          end
        end
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      hit         <= hit_next;
      zero_length <= zlen_in;
    end
  end

endmodule

[sim/tb_segment_box_intersection_test.sv]
module tb_segment_box_intersection_test;
  import sbit_pkg::*;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int SETTLE = FB + 10;

  typedef struct packed {
    logic signed [CW-1:0] sx, sy, sz, ex, ey, ez, lx, ly, lz, hx, hy, hz;
  } seg_t;

  typedef struct packed {
    logic hit;
    logic zero_length;
  } res_t;

  typedef struct {
    seg_t s;
    bit   known;
    res_t r;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  sbit_seg_if #(.W(CW)) seg ();
  sbit_res_if res ();

  segment_box_intersection_test #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) DUT (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .seg(seg.sink), .res(res.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #40000000;
    $display("tb_segment_box_intersection_test NOT OK");
    $finish;
  end

  logic [15:0] threshold;
  res_t hit_queue[$];
  int   fails = 0;
  int   row_fails = 0;
  bit   calm = 1'b0;     // no idling on either side
  bit   hold_off = 1'b0;

  logic [15:0] lim_vals[6] = '{16'd0, 16'd1, 16'd2, 16'd300, 16'h8000, 16'hffff};

  // Saturating n * 2^FB / d, rounded toward zero.
  function automatic longint clip_div(longint n, longint d);
    longint un, ud, q, lim;
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    lim = longint'(1) << (CW - 1);
    q = (un << FB) / ud;   // un < 2^33 so the shift stays in range
    if (q > lim) q = lim;
    if ((n < 0) != (d < 0)) return -q;
    if (q >= lim) q = lim - 1;
    return q;
  endfunction

  function automatic res_t clip_segment(seg_t s);
    res_t r;
    longint st[3], en[3], lo[3], hi[3];
    longint te, tl, dir, num, den, t, mg;
    st[0] = s.sx; st[1] = s.sy; st[2] = s.sz;
    en[0] = s.ex; en[1] = s.ey; en[2] = s.ez;
    lo[0] = s.lx; lo[1] = s.ly; lo[2] = s.lz;
    hi[0] = s.hx; hi[1] = s.hy; hi[2] = s.hz;
    r.zero_length = 1'b0;
    r.hit = 1'b1;
    if (st[0] == en[0] && st[1] == en[1] && st[2] == en[2]) begin
      r.hit = 1'b0;
      r.zero_length = 1'b1;
      return r;
    end
    te = 0;
    tl = longint'(1) << FB;
    for (int f = 0; f < NUM_FACES && r.hit; f++) begin
      dir = en[f/2] - st[f/2];
      if (f % 2 == 0) begin
        num = st[f/2] - lo[f/2];
        den = -dir;
      end else begin
        num = hi[f/2] - st[f/2];
        den = dir;
      end
      mg = den < 0 ? -den : den;
      if (den == 0 || mg < longint'(threshold)) begin
        if (num < 0) r.hit = 1'b0;
        continue;
      end
      t = clip_div(num, den);
      if (den < 0) begin
        if (t > te) begin
          te = t;
          if (te > tl) r.hit = 1'b0;
        end
      end else if (t < tl) begin
        tl = t;
        if (tl < te) r.hit = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return CW'($signed($urandom_range(0, 8)) - 4) << FB;
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return CW'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
    endcase
  endfunction

  function automatic seg_t rand_seg();
    seg_t s;
    logic [CW-1:0] a, b;
    s.sx = rand_coord(); s.sy = rand_coord(); s.sz = rand_coord();
    s.ex = rand_coord(); s.ey = rand_coord(); s.ez = rand_coord();
    a = rand_coord(); b = rand_coord();
    if ($urandom_range(0, 9) != 0 && $signed(a) > $signed(b)) begin
      s.lx = b; s.hx = a;
    end else begin
      s.lx = a; s.hx = b;
    end
    a = rand_coord(); b = rand_coord();
    if ($urandom_range(0, 9) != 0 && $signed(a) > $signed(b)) begin
      s.ly = b; s.hy = a;
    end else begin
      s.ly = a; s.hy = b;
    end
    a = rand_coord(); b = rand_coord();
    if ($urandom_range(0, 9) != 0 && $signed(a) > $signed(b)) begin
      s.lz = b; s.hz = a;
    end else begin
      s.lz = a; s.hz = b;
    end
    case ($urandom_range(0, 7))
      0: begin s.ex = s.sx; s.ey = s.sy; s.ez = s.sz; end
      1: s.ex = s.sx + CW'($urandom_range(0, 3));   // tiny direction, near threshold
      2: begin s.ey = s.sy; s.ez = s.sz; end
      default: ;
    endcase
    return s;
  endfunction

  function automatic seg_t mk(int sx, int sy, int sz, int ex, int ey, int ez,
                              int lx, int ly, int lz, int hx, int hy, int hz);
    seg_t s;
    s = {sx, sy, sz, ex, ey, ez, lx, ly, lz, hx, hy, hz};
    return s;
  endfunction

  // Leave valid high after the transfer; the next item or drain() drives it.
  task automatic send_segment(seg_t s);
    while (!calm && $urandom_range(0, 99) < 11) begin
      seg.valid <= 1'b0;
      @(posedge clk);
    end
    seg.valid <= 1'b1;
    {seg.start_x, seg.start_y, seg.start_z, seg.end_x, seg.end_y, seg.end_z,
     seg.box_low_x, seg.box_low_y, seg.box_low_z,
     seg.box_high_x, seg.box_high_y, seg.box_high_z} <= s;
    @(posedge clk);
    while (!seg.ready) @(posedge clk);
    hit_queue.push_back(clip_segment(s));
  endtask

  task automatic drain();
    seg.valid <= 1'b0;
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_threshold(logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    threshold = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      res.ready <= !hold_off && (calm || $urandom_range(0, 99) >= 11);
      if (res.valid && res.ready) begin
        if (hit_queue.size() == 0) begin
          $error("result transfer with nothing expected");
          fails++;
        end else begin
          res_t e;
          e = hit_queue.pop_front();
          if (res.hit !== e.hit) begin
            $error("hit: expected %0b actual %0b", e.hit, res.hit);
            fails++;
          end
          if (res.zero_length !== e.zero_length) begin
            $error("zero_length: expected %0b actual %0b", e.zero_length, res.zero_length);
            fails++;
          end
        end
      end
    end
  end

  row_t rows[$];

  initial begin
    threshold = 16'd1;
    seg.valid = 1'b0;
    {seg.start_x, seg.start_y, seg.start_z, seg.end_x, seg.end_y, seg.end_z,
     seg.box_low_x, seg.box_low_y, seg.box_low_z,
     seg.box_high_x, seg.box_high_y, seg.box_high_z} = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero length, both sign extremes
    rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1), 1, '{1'b0, 1'b1}});
    rows.push_back('{mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                        32'h80000000, 32'h80000000, 0, 0, 0, 0, 0, 0), 1, '{1'b0, 1'b1}});
    // plain crossing through a unit box
    rows.push_back('{mk(-65536, 32768, 32768, 131072, 32768, 32768,
                        0, 0, 0, 65536, 65536, 65536), 1, '{1'b1, 1'b0}});
    // parallel to y faces, start outside in y
    rows.push_back('{mk(0, 131072, 0, 65536, 131072, 0,
                        0, 0, 0, 65536, 65536, 65536), 1, '{1'b0, 1'b0}});
    // segment stops short of the box
    rows.push_back('{mk(-196608, 32768, 32768, -131072, 32768, 32768,
                        0, 0, 0, 65536, 65536, 65536), 1, '{1'b0, 1'b0}});
    // whole segment inside
    rows.push_back('{mk(16384, 16384, 16384, 49152, 49152, 49152,
                        0, 0, 0, 65536, 65536, 65536), 1, '{1'b1, 1'b0}});
    // inverted box, saturating quotients, extreme spans
    rows.push_back('{mk(32'h80000000, 0, 0, 32'h7fffffff, 1, 1, 65536, 0, 0,
                        0, 65536, 65536), 0, '{0, 0}});
    rows.push_back('{mk(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                        32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
                        32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 0, '{0, 0}});
    rows.push_back('{mk(0, 0, 0, 1, 0, 0, 32'h80000000, -1, -1, 32'h7fffffff, 1, 1), 0, '{0, 0}});
    rows.push_back('{mk(-1, -1, -1, 2, 2, 2, 0, 0, 0, 0, 0, 0), 0, '{0, 0}});
    rows.push_back('{mk(32'h7fffffff, 0, 0, 32'h7ffffffe, 0, 0,
                        32'h80000000, 0, 0, 32'h7fffffff, 0, 0), 0, '{0, 0}});
    foreach (rows[i]) begin
      send_segment(rows[i].s);
      if (rows[i].known && clip_segment(rows[i].s) !== rows[i].r) begin
        $error("directed row %0d: predictor disagrees with table", i);
        row_fails++;
      end
    end
    drain();

    foreach (lim_vals[k]) begin
      write_threshold(lim_vals[k]);
      repeat (150) send_segment(rand_seg());
      drain();
    end

    // long receiver hold-off while the sender keeps pushing
    fork
      begin
        hold_off <= 1'b1;
        repeat (200) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    repeat (120) send_segment(rand_seg());
    drain();

    // no idling stretch
    calm = 1'b1;
    write_threshold(16'hffff);
    repeat (300) send_segment(rand_seg());
    calm = 1'b0;
    drain();
    write_threshold(16'd1);
    repeat (400) send_segment(rand_seg());
    drain();

    if (fails == 0 && row_fails == 0) $display("tb_segment_box_intersection_test OK");
    else $display("tb_segment_box_intersection_test NOT OK");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/sbit_pkg.sv
hw/rtl/sbit_seg_if.sv
hw/rtl/sbit_res_if.sv
hw/rtl/sbit_prep.sv
hw/rtl/sbit_cell.sv
hw/rtl/sbit_final.sv
hw/rtl/segment_box_intersection_test.sv
sim/tb_segment_box_intersection_test.sv
